[rtl/rclp_pkg.sv]
package rclp_pkg;

    // result codes
    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_TURN     = 3'd1,
        ST_INVALID  = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NOT_SET  = 3'd5,
        ST_TOO_LONG = 3'd6
    } status_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ONE   = 8'h31;

    // bytes kept at fixed positions: command word plus azimuth digits
    localparam int HEAD_BYTES = 7;
    localparam int NUM_BYTES  = 4;
    localparam int AZ_MAX     = 359;
    localparam int AZ_W       = 9;
    localparam int QDEPTH     = 2;

    // one classified line (or an overflow report) handed to the back end
    typedef struct packed {
        logic                         too_long;
        logic                         bad_end;
        logic                         is_api;
        logic                         api_len_ok;
        logic                         is_am;
        logic [NUM_BYTES-1:0][7:0]    num_bytes;
    } line_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[rtl/rclp_front.sv]
module rclp_front import rclp_pkg::*; #(
    parameter int MAX_LINE = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_valid,
    input  logic [7:0]  byte_data,
    input  logic        q_full,
    output logic        byte_ready,
    output logic        push,
    output line_desc_t  push_desc
);

    localparam int FILL_W = $clog2(MAX_LINE + 1);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic              zseen_reg, zseen_next;
    logic [3:0]        zpos_reg, zpos_next;
    logic [7:0]        last_reg;
    logic [7:0]        head_reg [HEAD_BYTES];

    logic       accept, eol, full_line, store;
    logic [3:0] fill_cap, len_cap;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign eol        = (byte_data == CH_CR) || (byte_data == CH_LF);
    assign full_line  = (int'(fill_reg) >= MAX_LINE);
    assign store      = accept && !ovf_reg && !eol && !full_line;

    // text length saturated at 8, enough for the 3, 5 and 7 checks
    assign fill_cap = (int'(fill_reg) >= 8) ? 4'd8 : 4'(fill_reg);
    assign len_cap  = zseen_reg ? zpos_reg : fill_cap;

    assign push = accept && !ovf_reg &&
                  ((eol && (fill_reg != '0)) || (!eol && full_line));

    always_comb begin
        push_desc            = '0;
        push_desc.too_long   = !eol;
        push_desc.bad_end    = (int'(fill_reg) < 3) || (last_reg != CH_SEMI);
        push_desc.is_api     = (len_cap >= 4'd3) && (head_reg[0] == CH_A) &&
                               (head_reg[1] == CH_P) && (head_reg[2] == CH_I);
        push_desc.api_len_ok = (len_cap == 4'd7);
        push_desc.is_am      = (len_cap == 4'd5) && (head_reg[0] == CH_A) &&
                               (head_reg[1] == CH_M) && (head_reg[2] == CH_SPACE) &&
                               (head_reg[3] == CH_ONE) && (head_reg[4] == CH_SEMI);
        for (int i = 0; i < NUM_BYTES; i++) begin
            push_desc.num_bytes[i] = head_reg[3 + i];
        end
    end

    always_comb begin
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        zseen_next = zseen_reg;
        zpos_next  = zpos_reg;
        if (accept) begin
            if (eol) begin
                fill_next  = '0;
                ovf_next   = 1'b0;
                zseen_next = 1'b0;
            end else if (!ovf_reg && full_line) begin
                ovf_next = 1'b1;
            end else if (store) begin
                fill_next = fill_reg + 1'b1;
                if (byte_data == CH_NUL && !zseen_reg) begin
                    zseen_next = 1'b1;
                    zpos_next  = fill_cap;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            zseen_reg <= 1'b0;
            zpos_reg  <= '0;
        end else begin
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            zseen_reg <= zseen_next;
            zpos_reg  <= zpos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            last_reg <= byte_data;
            for (int i = 0; i < HEAD_BYTES; i++) begin
                if (int'(fill_reg) == i) begin
                    head_reg[i] <= byte_data;
                end
            end
        end
    end

endmodule

[rtl/rclp_queue.sv]
module rclp_queue import rclp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  line_desc_t  push_desc,
    input  logic        pop,
    output line_desc_t  head_desc,
    output queue_stat_t stat
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    line_desc_t         slot_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign stat.full  = (int'(count_reg) == QDEPTH);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_desc  = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (int'(p) == QDEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/rclp_back.sv]
module rclp_back import rclp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  line_desc_t        head_desc,
    input  queue_stat_t       q_stat,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output status_t           res_status,
    output logic [AZ_W-1:0]   res_azimuth
);

    localparam int VAL_W = 14;

    logic              valid_reg, valid_next;
    status_t           status_reg, status_next;
    logic [AZ_W-1:0]   az_out_reg, az_out_next;
    logic [AZ_W-1:0]   az_store_reg, az_store_next;
    logic              az_set_reg, az_set_next;
    logic              out_free;
    logic              neg;
    logic [VAL_W-1:0]  mag;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // atoi over the four azimuth bytes: blanks, optional sign, digits
    always_comb begin
        logic skipping, done;
        skipping = 1'b1;
        done     = 1'b0;
        neg      = 1'b0;
        mag      = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (!done) begin
                if (skipping && is_blank(head_desc.num_bytes[i])) begin
                    skipping = 1'b1;
                end else if (skipping && (head_desc.num_bytes[i] == CH_PLUS ||
                                          head_desc.num_bytes[i] == CH_MINUS)) begin
                    skipping = 1'b0;
                    neg      = (head_desc.num_bytes[i] == CH_MINUS);
                end else if (is_digit(head_desc.num_bytes[i])) begin
                    skipping = 1'b0;
                    mag      = (mag << 3) + (mag << 1) +
                               VAL_W'(head_desc.num_bytes[i] - CH_ZERO);
                end else begin
                    done = 1'b1;
                end
            end
        end
    end

    assign out_free = !valid_reg || res_ready;
    assign pop      = out_free && !q_stat.empty;

    always_comb begin
        valid_next    = valid_reg && !res_ready;
        status_next   = status_reg;
        az_out_next   = az_out_reg;
        az_store_next = az_store_reg;
        az_set_next   = az_set_reg;
        if (pop) begin
            valid_next  = 1'b1;
            az_out_next = '0;
            priority if (head_desc.too_long) begin
                status_next = ST_TOO_LONG;
            end else if (head_desc.bad_end) begin
                status_next = ST_INVALID;
            end else if (head_desc.is_api) begin
                if (!head_desc.api_len_ok) begin
                    status_next = ST_LENGTH;
                end else if ((neg && mag != '0) || (int'(mag) > AZ_MAX)) begin
                    status_next = ST_RANGE;
                end else begin
                    status_next   = ST_STORED;
                    az_store_next = AZ_W'(mag);
                    az_set_next   = 1'b1;
                end
            end else if (head_desc.is_am) begin
                if (az_set_reg) begin
                    status_next = ST_TURN;
                    az_out_next = az_store_reg;
                end else begin
                    status_next = ST_NOT_SET;
                end
            end else begin
                status_next = ST_INVALID;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            az_store_reg <= '0;
            az_set_reg   <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            az_store_reg <= az_store_next;
            az_set_reg   <= az_set_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        az_out_reg <= az_out_next;
    end

    assign res_valid   = valid_reg;
    assign res_status  = status_reg;
    assign res_azimuth = az_out_reg;

endmodule

[rtl/rotator_command_line_parser.sv]
// Rotator command line parser. Takes one received byte per transfer on the
// s_ side and gathers CR/LF-terminated lines of up to MAX_LINE bytes; each
// non-empty line gives one result transfer on the m_ side (status and the
// azimuth to turn to). "APIxxx;" stores an azimuth of 0..359, "AM 1;" asks
// for a turn to it. An over-long line gives one too-long report and the rest
// of it is dropped up to the next line end; empty lines give nothing. A byte
// is taken every cycle while the queue has room: the front end classifies each
// line as its bytes arrive, a two-entry queue holds finished lines, and the
// back end decodes one line per cycle into the output register while the
// result side accepts. The input stalls only when the queue is full because
// the result side is holding off.
module rotator_command_line_parser import rclp_pkg::*; #(
    parameter int MAX_LINE = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [11:3] turn_azimuth, rest zero
);

    // front to queue
    logic        push;
    line_desc_t  push_desc;

    // queue to back
    line_desc_t  head_desc;
    queue_stat_t q_stat;
    logic        pop;

    // result register
    status_t         res_status;
    logic [AZ_W-1:0] res_azimuth;

    rclp_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .q_full     (q_stat.full),
        .byte_ready (s_tready),
        .push       (push),
        .push_desc  (push_desc)
    );

    rclp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .stat      (q_stat)
    );

    rclp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_desc   (head_desc),
        .q_stat      (q_stat),
        .pop         (pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (res_status),
        .res_azimuth (res_azimuth)
    );

    // pack result fields, lowest first, padded to two bytes
    assign m_tdata = {4'b0000, res_azimuth, res_status};

    // azimuth only rides along with a turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_status != ST_TURN) |-> (res_azimuth == '0))
        else $error("azimuth nonzero on a non-turn result");

    // a turned-to azimuth was range checked when stored
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_status == ST_TURN) |-> (int'(res_azimuth) <= AZ_MAX))
        else $error("turn azimuth out of range");

    // a line is never pushed into a full queue, since input is held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !push)
        else $error("line pushed into full queue");

    // the queue cannot be full and empty at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rclp_pkg::*;

    localparam int LINE_MAX     = 12;
    localparam int GAP_MAX      = 15;     // longest per-item wait on either side
    localparam int LONG_HOLD    = 240;    // receiver hold-off used to fill the parser
    localparam int QUIET_LIMIT  = 2000;   // cycles without any transfer before giving up
    localparam int RANDOM_BYTES = 1200;
    localparam int TAIL_CYCLES  = 16;     // idle tail before the last check for missing replies

    // one decoded command as it leaves the parser
    typedef struct {
        status_t    status;
        logic [8:0] azimuth;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [2:0] status, [11:3] turn_azimuth, [15:12] zero

    // shadow of the parser: line buffer, drop mode and the stored azimuth
    logic [7:0]  line_buf [LINE_MAX];
    int          fill_cnt  = 0;
    logic        dropping  = 1'b0;
    logic [8:0]  az_reg    = '0;
    logic        az_set    = 1'b0;

    reply_t      pending_replies[$];   // decoded commands still to come out
    logic [7:0]  line_q[$];            // bytes of the line being assembled
    int          live_bytes = 0;       // bytes the parser actually had to look at
    int          fail_count = 0;

    // traffic shaping, written only by the test sequence
    logic        tx_idle = 1'b1;
    logic        rx_idle = 1'b1;
    int          hold_requests = 0;

    rotator_command_line_parser #(
        .MAX_LINE (LINE_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // command decoder shadow
    // ------------------------------------------------------------------

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // decode the finished line held in line_buf; may update the azimuth
    function automatic reply_t decode_command();
        reply_t r;
        int     text_len;
        int     i;
        int     val;
        logic   neg;
        r.status  = ST_INVALID;
        r.azimuth = '0;
        if (fill_cnt < 3 || line_buf[fill_cnt-1] != CH_SEMI)
            return r;
        // a nul byte cuts the text short; the semicolon test above does not care
        text_len = fill_cnt;
        for (i = fill_cnt - 1; i >= 0; i--)
            if (line_buf[i] == CH_NUL)
                text_len = i;
        if (text_len >= 3 && line_buf[0] == CH_A && line_buf[1] == CH_P
            && line_buf[2] == CH_I) begin
            if (text_len != 7) begin
                r.status = ST_LENGTH;
            end else begin
                // atoi over the four bytes after the command word
                i   = 3;
                neg = 1'b0;
                val = 0;
                while (i < 7 && is_blank(line_buf[i]))
                    i++;
                if (i < 7 && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS)) begin
                    neg = line_buf[i] == CH_MINUS;
                    i++;
                end
                while (i < 7 && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE) begin
                    val = val * 10 + int'(line_buf[i] - CH_ZERO);
                    i++;
                end
                if (neg)
                    val = -val;
                if (val < 0 || val > AZ_MAX) begin
                    r.status = ST_RANGE;
                end else begin
                    az_reg   = val[8:0];
                    az_set   = 1'b1;
                    r.status = ST_STORED;
                end
            end
        end else if (text_len == 5 && line_buf[0] == CH_A && line_buf[1] == CH_M
                     && line_buf[2] == CH_SPACE && line_buf[3] == CH_ONE
                     && line_buf[4] == CH_SEMI) begin
            if (!az_set) begin
                r.status = ST_NOT_SET;
            end else begin
                r.status  = ST_TURN;
                r.azimuth = az_reg;
            end
        end
        return r;
    endfunction

    // follow one accepted byte through the parser and queue any reply
    task automatic track_byte(input logic [7:0] c);
        logic   eol;
        reply_t r;
        eol = (c == CH_CR || c == CH_LF);
        if (dropping) begin
            // rest of an over-long line, silently swallowed
            if (eol) begin
                dropping = 1'b0;
                fill_cnt = 0;
            end
        end else if (eol) begin
            if (fill_cnt != 0) begin
                pending_replies.push_back(decode_command());
                fill_cnt = 0;
                live_bytes++;
            end
        end else if (fill_cnt >= LINE_MAX) begin
            dropping  = 1'b1;
            r.status  = ST_TOO_LONG;
            r.azimuth = '0;
            pending_replies.push_back(r);
            live_bytes++;
        end else begin
            line_buf[fill_cnt] = c;
            fill_cnt++;
            live_bytes++;
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one byte transfer, with a random gap in front when the sender idles
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        track_byte(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    // send the assembled line followed by its terminator
    task automatic send_line_q(input logic [7:0] term);
        foreach (line_q[i])
            send_byte(line_q[i]);
        send_byte(term);
        line_q.delete();
    endtask

    task automatic send_cmd(input string s);
        push_text(s);
        send_line_q(CH_CR);
    endtask

    // sender pause: nothing offered until every reply is out
    task automatic wait_replies_done;
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall per reply, plus the long hold on request
    // ------------------------------------------------------------------

    int   stall_left  = 0;
    int   holds_done  = 0;
    logic hold_active = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                stall_left = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            else if (stall_left > 0 && (m_tvalid || hold_active))
                stall_left--;   // per-reply stalls only count while a reply waits
            if (hold_requests != holds_done) begin
                holds_done  = hold_requests;
                stall_left  = LONG_HOLD;
                hold_active = 1'b1;
            end
            if (stall_left == 0)
                hold_active = 1'b0;
            m_tready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // reply checker
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: reply with none pending, expected none actual %h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[11:3] !== want.azimuth) begin
                    $display("%0t: azimuth mismatch, expected %0d actual %0d",
                             $time, want.azimuth, m_tdata[11:3]);
                    fail_count++;
                end
                if (m_tdata[15:12] !== 4'h0) begin
                    $display("%0t: padding mismatch, expected 0 actual %h",
                             $time, m_tdata[15:12]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer on either side
    // ------------------------------------------------------------------

    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("rotator_command_line_parser verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // fresh parser: empty lines are silent, turn has no azimuth yet
    task automatic test_power_up;
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_cmd("AM 1;");
        send_cmd("API12;");
        send_cmd("API360;");   // out of range must not set the azimuth
        send_cmd("AM 1;");
    endtask

    // azimuth store and turn, including the atoi corner cases
    task automatic test_azimuth_forms;
        send_cmd("API000;");
        send_cmd("AM 1;");
        send_cmd("API359;");
        send_cmd("AM 1;");
        send_cmd("API +5;");
        send_cmd("API\t-0;");   // negative zero is still zero
        send_cmd("API-01;");
        send_cmd("APIabc;");    // no digits parses as zero
        send_cmd("API12x;");
        send_cmd("API+-1;");
        // vertical tab and form feed count as leading white space
        push_text("API");
        line_q.push_back(8'h0b);
        line_q.push_back(8'h0c);
        push_text("7;");
        send_line_q(CH_LF);
        send_cmd("AM 1;");
    endtask

    // bad endings, wrong lengths and embedded nul bytes
    task automatic test_line_errors;
        send_cmd("AM 1");
        send_cmd("A;");
        send_cmd(";");
        send_cmd("AM 1;;");
        send_cmd("am 1;");
        send_cmd("API1234;");
        // nul after the turn command: text ends there, last byte still ';'
        push_text("AM 1;");
        line_q.push_back(CH_NUL);
        push_text("x;");
        send_line_q(CH_LF);
        push_text("API");
        line_q.push_back(CH_NUL);
        push_text("123;");
        send_line_q(CH_CR);
        push_text("AM ");
        line_q.push_back(8'hff);
        push_text(";");
        send_line_q(CH_CR);
    endtask

    // full line, then over-long lines dropped up to the next line end
    task automatic test_overflow;
        send_cmd("AM 1;AM 1;A;");
        send_cmd("API123;API123;");
        push_text("0123456789abcdefgh");
        send_line_q(CH_LF);
        send_byte(CH_LF);
        send_cmd("AM 1;");
    endtask

    // receiver holds off while back-to-back lines pile up at the input
    task automatic test_backpressure;
        tx_idle = 1'b0;
        hold_requests++;
        repeat (30) begin
            send_cmd("AM 1;");
            send_cmd("API042;");
        end
        wait_replies_done;
        tx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // random traffic
    // ------------------------------------------------------------------

    task automatic build_api_number;
        int    v;
        int    idx;
        string pool;
        string lead;
        pool = "0123456789 +-\tx";
        lead = " \t+-";
        push_text("API");
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                v = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 359)
                                                : $urandom_range(360, 999);
                line_q.push_back(8'(CH_ZERO + v / 100));
                line_q.push_back(8'(CH_ZERO + (v / 10) % 10));
                line_q.push_back(8'(CH_ZERO + v % 10));
            end
            3: begin
                idx = $urandom_range(0, 5);
                line_q.push_back(idx < 4 ? lead[idx] : 8'(8'h0b + idx - 4));
                v = $urandom_range(0, 99);
                line_q.push_back(8'(CH_ZERO + v / 10));
                line_q.push_back(8'(CH_ZERO + v % 10));
            end
            4: begin
                repeat (3) line_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            end
            default: begin
                repeat (3) line_q.push_back(8'($urandom_range(32, 126)));
            end
        endcase
        line_q.push_back(CH_SEMI);
    endtask

    task automatic build_random_line;
        line_q.delete();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: build_api_number();
            5, 6, 7:       push_text("AM 1;");
            8: begin
                // one byte of a good command replaced by anything
                if ($urandom_range(0, 1) != 0)
                    push_text("AM 1;");
                else
                    build_api_number();
                line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            9: begin
                push_text("API");
                repeat ($urandom_range(0, 6))
                    line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                line_q.push_back(CH_SEMI);
            end
            10: begin
                repeat ($urandom_range(13, 20))
                    line_q.push_back(8'($urandom_range(32, 255)));
            end
            11: begin
                if ($urandom_range(0, 1) != 0)
                    push_text("AM 1;");
                else
                    build_api_number();
                line_q.insert($urandom_range(0, line_q.size()), CH_NUL);
            end
            12: begin
                repeat (LINE_MAX - 1) line_q.push_back(8'($urandom_range(32, 126)));
                line_q.push_back(CH_SEMI);
            end
            13: begin
                if ($urandom_range(0, 1) != 0)
                    line_q.push_back(8'($urandom_range(32, 126)));
                line_q.push_back($urandom_range(0, 1) != 0 ? CH_SEMI : 8'h41);
            end
            default: begin
                // raw noise, line ends included
                repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic test_random_traffic;
        int goal;
        goal = live_bytes + RANDOM_BYTES;
        while (live_bytes < goal) begin
            // switch idling on and off so that bursts and gaps both occur
            if ($urandom_range(0, 11) == 0)
                tx_idle = !tx_idle;
            if ($urandom_range(0, 11) == 0)
                rx_idle = !rx_idle;
            build_random_line();
            send_line_q($urandom_range(0, 1) != 0 ? CH_CR : CH_LF);
            if ($urandom_range(0, 3) == 0)
                send_byte(CH_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        foreach (line_buf[i])
            line_buf[i] = CH_NUL;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_up();
        test_azimuth_forms();
        test_line_errors();
        test_overflow();
        test_backpressure();
        test_random_traffic();

        wait_replies_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, pending_replies.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("rotator_command_line_parser verification clean");
        else
            $display("rotator_command_line_parser verification failed");
        $finish;
    end

endmodule
